// ===== hdl/srrqs_pkg.sv =====
// shared types and codes for the slot reserved run queue scheduler
package srrqs_pkg;

   localparam logic [2:0] FN_APPEND   = 3'd0;
   localparam logic [2:0] FN_PREPEND  = 3'd1;
   localparam logic [2:0] FN_REMOVE   = 3'd2;
   localparam logic [2:0] FN_SCHEDULE = 3'd3;
   localparam logic [2:0] FN_GRANT    = 3'd4;
   localparam logic [2:0] FN_QUERY    = 3'd5;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_RANGE = 3'd1;
   localparam logic [2:0] ST_HELD  = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_QERR  = 3'd4;

   localparam logic [15:0] TICKS_RESET = 16'd10;
   localparam logic [5:0]  DIV_STEPS   = 6'd32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LINK,
      S_DIV,
      S_SCHED,
      S_UNLINK,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_SET_RANGE,
      DP_SET_QERR,
      DP_SET_EMPTY,
      DP_LINK_EMPTY,
      DP_LINK_A,
      DP_LINK_B,
      DP_READ_LINKS,
      DP_UNLINK,
      DP_DIV_START,
      DP_DIV_STEP,
      DP_SCHED_PICK,
      DP_GRANT,
      DP_QUERY
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       range_err;
      logic       queued;
      logic       head_nil;
      logic       remove_err;
      logic       div_done;
      logic       sched_empty;
   } stat_type;

endpackage

// ===== hdl/srrqs_ctrl.sv =====
// controller state machine sequencing each item through the datapath
module srrqs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  srrqs_pkg::stat_type stat,
   output srrqs_pkg::cmd_type  cmd
);

   srrqs_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == srrqs_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srrqs_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srrqs_pkg::S_IDLE: begin
            if (req_valid) state_in = srrqs_pkg::S_EXEC;
         end
         srrqs_pkg::S_EXEC: begin
            state_in = srrqs_pkg::S_DONE;
            if (!stat.range_err) begin
               case (stat.func)
                  srrqs_pkg::FN_APPEND, srrqs_pkg::FN_PREPEND: begin
                     if (!stat.queued && !stat.head_nil) state_in = srrqs_pkg::S_LINK;
                  end
                  srrqs_pkg::FN_REMOVE: begin
                     if (stat.queued) state_in = srrqs_pkg::S_UNLINK;
                  end
                  srrqs_pkg::FN_SCHEDULE: state_in = srrqs_pkg::S_DIV;
                  default: state_in = srrqs_pkg::S_DONE;
               endcase
            end
         end
         srrqs_pkg::S_LINK: state_in = srrqs_pkg::S_DONE;
         srrqs_pkg::S_DIV: begin
            if (stat.div_done) state_in = srrqs_pkg::S_SCHED;
         end
         srrqs_pkg::S_SCHED: begin
            state_in = stat.sched_empty ? srrqs_pkg::S_DONE : srrqs_pkg::S_UNLINK;
         end
         srrqs_pkg::S_UNLINK: state_in = srrqs_pkg::S_DONE;
         srrqs_pkg::S_DONE: begin
            if (out_free) state_in = srrqs_pkg::S_IDLE;
         end
         default: state_in = srrqs_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op       = srrqs_pkg::DP_NONE;
      cmd.out_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         srrqs_pkg::S_IDLE: begin
            if (req_valid) cmd.op = srrqs_pkg::DP_LOAD;
         end
         srrqs_pkg::S_EXEC: begin
            if (stat.range_err) begin
               cmd.op = srrqs_pkg::DP_SET_RANGE;
            end else begin
               case (stat.func)
                  srrqs_pkg::FN_APPEND, srrqs_pkg::FN_PREPEND: begin
                     if (stat.queued)        cmd.op = srrqs_pkg::DP_SET_QERR;
                     else if (stat.head_nil) cmd.op = srrqs_pkg::DP_LINK_EMPTY;
                     else                    cmd.op = srrqs_pkg::DP_LINK_A;
                  end
                  srrqs_pkg::FN_REMOVE: begin
                     cmd.op = stat.queued ? srrqs_pkg::DP_READ_LINKS
                                          : srrqs_pkg::DP_SET_QERR;
                  end
                  srrqs_pkg::FN_SCHEDULE: cmd.op = srrqs_pkg::DP_DIV_START;
                  srrqs_pkg::FN_GRANT:    cmd.op = srrqs_pkg::DP_GRANT;
                  srrqs_pkg::FN_QUERY:    cmd.op = srrqs_pkg::DP_QUERY;
                  default:                cmd.op = srrqs_pkg::DP_SET_RANGE;
               endcase
            end
         end
         srrqs_pkg::S_LINK: cmd.op = srrqs_pkg::DP_LINK_B;
         srrqs_pkg::S_DIV: begin
            if (!stat.div_done) cmd.op = srrqs_pkg::DP_DIV_STEP;
         end
         srrqs_pkg::S_SCHED: begin
            cmd.op = stat.sched_empty ? srrqs_pkg::DP_SET_EMPTY : srrqs_pkg::DP_SCHED_PICK;
         end
         srrqs_pkg::S_UNLINK: begin
            cmd.op = stat.remove_err ? srrqs_pkg::DP_SET_QERR : srrqs_pkg::DP_UNLINK;
         end
         srrqs_pkg::S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.op = srrqs_pkg::DP_NONE;
      endcase
   end

endmodule

// ===== hdl/srrqs_dp.sv =====
// datapath: run queues, link memories, slot table, slot divider and result registers
module srrqs_dp #(
   parameter int NUM_ACCOUNTS = 16,
   parameter int MAX_THREADS  = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  srrqs_pkg::cmd_type  cmd,
   output srrqs_pkg::stat_type stat,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   input  logic [2:0]          req_func,
   input  logic [5:0]          req_thread_id,
   input  logic [7:0]          req_account,
   input  logic [7:0]          req_slot,
   input  logic [31:0]         req_now,
   output logic [2:0]          rsp_status,
   output logic [5:0]          rsp_picked_thread,
   output logic [7:0]          rsp_slot_owner
);

   localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int LW = $clog2(MAX_THREADS + 1);
   localparam int AW = (NUM_ACCOUNTS > 1) ? $clog2(NUM_ACCOUNTS) : 1;
   localparam logic [LW-1:0] NIL   = LW'(MAX_THREADS);
   localparam logic [AW:0]   NUM_W = (AW+1)'(NUM_ACCOUNTS);

   // control state
   logic [15:0]   ticks_ff;
   logic [MAX_THREADS-1:0] queued_ff;
   logic [LW-1:0] head_ff    [NUM_ACCOUNTS];
   logic [LW-1:0] tail_ff    [NUM_ACCOUNTS];
   logic [NUM_ACCOUNTS-1:0] granted_ff;
   logic [AW-1:0] owner_ff   [NUM_ACCOUNTS];

   // link memories
   logic [LW-1:0] next_mem [MAX_THREADS];
   logic [LW-1:0] prev_mem [MAX_THREADS];
   logic [LW-1:0] rd_next_ff, rd_prev_ff;

   // item registers
   logic [2:0]    func_ff;
   logic [5:0]    tid_ff;
   logic [7:0]    acc_ff;
   logic [7:0]    slot_ff;
   logic [LW-1:0] cur_ff;
   logic [AW-1:0] cur_acc_ff;

   // divider
   logic [31:0]   dvd_ff;
   logic [15:0]   rem_ff;
   logic [5:0]    cnt_ff;
   logic [AW-1:0] modr_ff;

   logic [2:0]    res_status_ff;
   logic [5:0]    res_picked_ff;
   logic [7:0]    res_owner_ff;
   logic [2:0]    rsp_status_ff;
   logic [5:0]    rsp_picked_ff;
   logic [7:0]    rsp_owner_ff;

   logic [TW-1:0] cur_idx;
   logic [AW-1:0] slot_idx;
   logic [LW-1:0] head_cur, tail_cur;
   logic          prepend;
   logic [15:0]   divisor;
   logic [16:0]   rem_sh;
   logic          qbit;
   logic [15:0]   rem_nx;
   logic [AW:0]   mod_sh;
   logic [AW-1:0] mod_nx;
   logic [AW-1:0] sched_acc;
   logic [LW-1:0] sched_head;
   logic          held;
   logic          range_err;

   logic          nwe, pwe, rd_en;
   logic [TW-1:0] nwa, pwa, rd_addr;
   logic [LW-1:0] nwd, pwd;

   assign cur_idx  = cur_ff[TW-1:0];
   assign slot_idx = slot_ff[AW-1:0];
   assign head_cur = head_ff[cur_acc_ff];
   assign tail_cur = tail_ff[cur_acc_ff];
   assign prepend  = (func_ff == srrqs_pkg::FN_PREPEND);

   // restoring divide, one quotient bit a step, folding the quotient mod the account count
   assign divisor = (ticks_ff == 16'd0) ? 16'd1 : ticks_ff;
   assign rem_sh  = {rem_ff, dvd_ff[31]};
   assign qbit    = (rem_sh >= {1'b0, divisor});
   assign rem_nx  = qbit ? 16'(rem_sh - {1'b0, divisor}) : rem_sh[15:0];
   assign mod_sh  = {modr_ff, qbit};
   assign mod_nx  = (mod_sh >= NUM_W) ? AW'(mod_sh - NUM_W) : mod_sh[AW-1:0];

   assign sched_acc  = granted_ff[modr_ff] ? owner_ff[modr_ff] : '0;
   assign sched_head = head_ff[sched_acc];
   assign held       = granted_ff[slot_idx] && (owner_ff[slot_idx] != AW'(acc_ff));

   always_comb begin
      case (func_ff)
         srrqs_pkg::FN_APPEND, srrqs_pkg::FN_PREPEND, srrqs_pkg::FN_REMOVE:
            range_err = (32'(tid_ff) >= 32'(MAX_THREADS))
                     || (32'(acc_ff) >= 32'(NUM_ACCOUNTS));
         srrqs_pkg::FN_SCHEDULE: range_err = 1'b0;
         srrqs_pkg::FN_GRANT:
            range_err = (32'(slot_ff) >= 32'(NUM_ACCOUNTS))
                     || (32'(acc_ff) >= 32'(NUM_ACCOUNTS));
         srrqs_pkg::FN_QUERY: range_err = (32'(slot_ff) >= 32'(NUM_ACCOUNTS));
         default: range_err = 1'b1;
      endcase
   end

   assign stat.range_err   = range_err;
   assign stat.func        = func_ff;
   assign stat.queued      = queued_ff[cur_idx];
   assign stat.head_nil    = (head_cur == NIL);
   assign stat.remove_err  = ((rd_prev_ff == NIL) && (head_cur != cur_ff))
                          || ((rd_next_ff == NIL) && (tail_cur != cur_ff));
   assign stat.div_done    = (cnt_ff == 6'd0);
   assign stat.sched_empty = (sched_head == NIL);

   // link memory ports
   always_comb begin
      nwe     = 1'b0;
      pwe     = 1'b0;
      nwa     = cur_idx;
      pwa     = cur_idx;
      nwd     = NIL;
      pwd     = NIL;
      rd_en   = 1'b0;
      rd_addr = cur_idx;
      case (cmd.op)
         srrqs_pkg::DP_LINK_EMPTY: begin
            nwe = 1'b1;
            pwe = 1'b1;
         end
         srrqs_pkg::DP_LINK_A: begin
            nwe = 1'b1;
            pwe = 1'b1;
            if (prepend) nwd = head_cur;
            else         pwd = tail_cur;
         end
         srrqs_pkg::DP_LINK_B: begin
            if (prepend) begin
               pwe = 1'b1;
               pwa = head_cur[TW-1:0];
               pwd = cur_ff;
            end else begin
               nwe = 1'b1;
               nwa = tail_cur[TW-1:0];
               nwd = cur_ff;
            end
         end
         srrqs_pkg::DP_UNLINK: begin
            nwe = (rd_prev_ff != NIL);
            nwa = rd_prev_ff[TW-1:0];
            nwd = rd_next_ff;
            pwe = (rd_next_ff != NIL);
            pwa = rd_next_ff[TW-1:0];
            pwd = rd_prev_ff;
         end
         srrqs_pkg::DP_READ_LINKS: rd_en = 1'b1;
         srrqs_pkg::DP_SCHED_PICK: begin
            rd_en   = 1'b1;
            rd_addr = sched_head[TW-1:0];
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (nwe) next_mem[nwa] <= nwd;
      if (pwe) prev_mem[pwa] <= pwd;
      if (rd_en) begin
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
   end

   // queue and slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff   <= srrqs_pkg::TICKS_RESET;
         queued_ff  <= '0;
         granted_ff <= '0;
         for (int i = 0; i < NUM_ACCOUNTS; i++) begin
            head_ff[i]  <= NIL;
            tail_ff[i]  <= NIL;
            owner_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) ticks_ff <= csr_wr_data;
         case (cmd.op)
            srrqs_pkg::DP_LINK_EMPTY: begin
               head_ff[cur_acc_ff] <= cur_ff;
               tail_ff[cur_acc_ff] <= cur_ff;
               queued_ff[cur_idx]  <= 1'b1;
            end
            srrqs_pkg::DP_LINK_B: begin
               if (prepend) head_ff[cur_acc_ff] <= cur_ff;
               else         tail_ff[cur_acc_ff] <= cur_ff;
               queued_ff[cur_idx] <= 1'b1;
            end
            srrqs_pkg::DP_UNLINK: begin
               if (rd_prev_ff == NIL) head_ff[cur_acc_ff] <= rd_next_ff;
               if (rd_next_ff == NIL) tail_ff[cur_acc_ff] <= rd_prev_ff;
               queued_ff[cur_idx] <= 1'b0;
            end
            srrqs_pkg::DP_GRANT: begin
               if (!held) begin
                  granted_ff[slot_idx] <= 1'b1;
                  owner_ff[slot_idx]   <= AW'(acc_ff);
               end
            end
            default: ;
         endcase
      end
   end

   // item, divider and result registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         srrqs_pkg::DP_LOAD: begin
            func_ff       <= req_func;
            tid_ff        <= req_thread_id;
            acc_ff        <= req_account;
            slot_ff       <= req_slot;
            dvd_ff        <= req_now;
            cur_ff        <= LW'(req_thread_id);
            cur_acc_ff    <= AW'(req_account);
            res_status_ff <= srrqs_pkg::ST_OK;
            res_picked_ff <= '0;
            res_owner_ff  <= '0;
         end
         srrqs_pkg::DP_SET_RANGE: res_status_ff <= srrqs_pkg::ST_RANGE;
         srrqs_pkg::DP_SET_QERR:  res_status_ff <= srrqs_pkg::ST_QERR;
         srrqs_pkg::DP_SET_EMPTY: res_status_ff <= srrqs_pkg::ST_EMPTY;
         srrqs_pkg::DP_DIV_START: begin
            rem_ff  <= '0;
            cnt_ff  <= srrqs_pkg::DIV_STEPS;
            modr_ff <= '0;
         end
         srrqs_pkg::DP_DIV_STEP: begin
            dvd_ff  <= {dvd_ff[30:0], 1'b0};
            rem_ff  <= rem_nx;
            cnt_ff  <= cnt_ff - 6'd1;
            modr_ff <= mod_nx;
         end
         srrqs_pkg::DP_SCHED_PICK: begin
            cur_ff     <= sched_head;
            cur_acc_ff <= sched_acc;
         end
         srrqs_pkg::DP_UNLINK: begin
            if (func_ff == srrqs_pkg::FN_SCHEDULE) res_picked_ff <= 6'(cur_ff);
         end
         srrqs_pkg::DP_GRANT: begin
            if (held) res_status_ff <= srrqs_pkg::ST_HELD;
         end
         srrqs_pkg::DP_QUERY: begin
            res_owner_ff <= granted_ff[slot_idx] ? 8'(owner_ff[slot_idx]) : 8'd0;
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_picked_ff <= res_picked_ff;
         rsp_owner_ff  <= res_owner_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_picked_thread = rsp_picked_ff;
   assign rsp_slot_owner    = rsp_owner_ff;

endmodule

// ===== hdl/slot_reserved_run_queue_scheduler.sv =====
// Per-account run queues with a time slot reservation table. One item is worked at a time.
// After acceptance each item passes the execute state and ends in the done state, which loads
// its result into the output register. Grant, query, range errors, appends of a queued thread,
// removes of a thread that is not queued and appends or prepends to an empty queue go straight
// to done; other appends and prepends pass a link state, other removes an unlink state, and
// schedule passes the one-bit-per-cycle divider that turns now into a slot (32 steps and a check
// for the end), a pick state and, unless the chosen queue is empty, an unlink state. The link
// memories have one write port each and a registered read, so a remove or a schedule reads a
// thread's links in the state before the one that unlinks it. While an earlier result waits in
// the output register the item holds in done, then goes to idle to accept the next item.
module slot_reserved_run_queue_scheduler #(
   parameter int NUM_ACCOUNTS = 16,
   parameter int MAX_THREADS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [5:0]  req_thread_id,
   input  logic [7:0]  req_account,
   input  logic [7:0]  req_slot,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_picked_thread,
   output logic [7:0]  rsp_slot_owner,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   srrqs_pkg::cmd_type  cmd;
   srrqs_pkg::stat_type stat;

   srrqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   srrqs_dp #(
      .NUM_ACCOUNTS (NUM_ACCOUNTS),
      .MAX_THREADS  (MAX_THREADS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_func          (req_func),
      .req_thread_id     (req_thread_id),
      .req_account       (req_account),
      .req_slot          (req_slot),
      .req_now           (req_now),
      .rsp_status        (rsp_status),
      .rsp_picked_thread (rsp_picked_thread),
      .rsp_slot_owner    (rsp_slot_owner)
   );

endmodule

// ===== hdl/srrqs_checker.sv =====
// port level checks for the scheduler, bound to the top level
module srrqs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [5:0] rsp_picked_thread,
   input logic [7:0] rsp_slot_owner
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a failed item carries no thread and no owner
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != srrqs_pkg::ST_OK)
         |-> (rsp_picked_thread == 6'd0) && (rsp_slot_owner == 8'd0))
      else $error("failed item carries data");

endmodule

bind slot_reserved_run_queue_scheduler srrqs_checker u_srrqs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_picked_thread (rsp_picked_thread),
   .rsp_slot_owner    (rsp_slot_owner)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the slot reserved run queue scheduler
module tb_top;

   localparam int NACC = 16;
   localparam int NTHR = 64;
   localparam logic [6:0] NIL = 7'd64;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 300;

   typedef struct {
      logic [2:0]  func;
      logic [5:0]  tid;
      logic [7:0]  acc;
      logic [7:0]  slot;
      logic [31:0] now;
      bit          typed;
      logic [2:0]  status;
      logic [5:0]  picked;
      logic [7:0]  owner;
   } row_type;

   typedef struct {
      logic [2:0] status;
      logic [5:0] picked;
      logic [7:0] owner;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [5:0]  req_thread_id = '0;
   logic [7:0]  req_account = '0;
   logic [7:0]  req_slot = '0;
   logic [31:0] req_now = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_picked_thread;
   logic [7:0]  rsp_slot_owner;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   slot_reserved_run_queue_scheduler #(.NUM_ACCOUNTS(NACC), .MAX_THREADS(NTHR)) u_top (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_thread_id, .req_account,
      .req_slot, .req_now, .rsp_valid, .rsp_ready, .rsp_status, .rsp_picked_thread,
      .rsp_slot_owner, .csr_wr_en, .csr_wr_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scheduler state mirror
   logic [6:0]  link_next [NTHR];
   logic [6:0]  link_prev [NTHR];
   bit          on_queue [NTHR];
   logic [3:0]  home_acc [NTHR];
   logic [6:0]  q_head [NACC];
   logic [6:0]  q_tail [NACC];
   bit          granted [NACC];
   logic [3:0]  slot_holder [NACC];
   logic [15:0] ticks_cfg = srrqs_pkg::TICKS_RESET;

   rsp_type pending_rsp [$];
   int    err_count = 0;
   int    accepted = 0;
   int    rsp_seen = 0;
   int    status_hist [8];
   int    hold_cycles = 0;

   function automatic void queue_unlink(logic [6:0] t, logic [3:0] a);
      logic [6:0] n;
      logic [6:0] p;
      n = link_next[t];
      p = link_prev[t];
      if (p == NIL) q_head[a] = n; else link_next[p] = n;
      if (n == NIL) q_tail[a] = p; else link_prev[n] = p;
      link_next[t] = NIL;
      link_prev[t] = NIL;
      on_queue[t] = 0;
   endfunction

   function automatic rsp_type sched_step(logic [2:0] func, logic [5:0] tid, logic [7:0] acc,
                                          logic [7:0] slot, logic [31:0] now);
      rsp_type r;
      int unsigned dv;
      int unsigned s;
      logic [3:0] a;
      logic [6:0] h;
      r = '{srrqs_pkg::ST_OK, 6'd0, 8'd0};
      case (func)
         srrqs_pkg::FN_APPEND, srrqs_pkg::FN_PREPEND: begin
            if (acc >= NACC) r.status = srrqs_pkg::ST_RANGE;
            else if (on_queue[tid]) r.status = srrqs_pkg::ST_QERR;
            else begin
               a = acc[3:0];
               if (q_head[a] == NIL) begin
                  link_next[tid] = NIL;
                  link_prev[tid] = NIL;
                  q_head[a] = {1'b0, tid};
                  q_tail[a] = {1'b0, tid};
               end else if (func == srrqs_pkg::FN_PREPEND) begin
                  link_next[tid] = q_head[a];
                  link_prev[tid] = NIL;
                  link_prev[q_head[a]] = {1'b0, tid};
                  q_head[a] = {1'b0, tid};
               end else begin
                  link_prev[tid] = q_tail[a];
                  link_next[tid] = NIL;
                  link_next[q_tail[a]] = {1'b0, tid};
                  q_tail[a] = {1'b0, tid};
               end
               on_queue[tid] = 1;
               home_acc[tid] = a;
            end
         end
         srrqs_pkg::FN_REMOVE: begin
            if (acc >= NACC) r.status = srrqs_pkg::ST_RANGE;
            else if (!on_queue[tid]) r.status = srrqs_pkg::ST_QERR;
            else if ((link_prev[tid] == NIL && q_head[acc[3:0]] != {1'b0, tid}) ||
                     (link_next[tid] == NIL && q_tail[acc[3:0]] != {1'b0, tid}))
               r.status = srrqs_pkg::ST_QERR;
            else queue_unlink({1'b0, tid}, acc[3:0]);
         end
         srrqs_pkg::FN_SCHEDULE: begin
            dv = (ticks_cfg == 0) ? 1 : ticks_cfg;
            s = (now / dv) % NACC;
            a = granted[s] ? slot_holder[s] : 4'd0;
            h = q_head[a];
            if (h == NIL) r.status = srrqs_pkg::ST_EMPTY;
            else begin
               queue_unlink(h, a);
               r.picked = h[5:0];
            end
         end
         srrqs_pkg::FN_GRANT: begin
            if (slot >= NACC || acc >= NACC) r.status = srrqs_pkg::ST_RANGE;
            else if (granted[slot] && slot_holder[slot] != acc[3:0])
               r.status = srrqs_pkg::ST_HELD;
            else begin
               granted[slot] = 1;
               slot_holder[slot] = acc[3:0];
            end
         end
         srrqs_pkg::FN_QUERY: begin
            if (slot >= NACC) r.status = srrqs_pkg::ST_RANGE;
            else r.owner = granted[slot] ? {4'd0, slot_holder[slot]} : 8'd0;
         end
         default: r.status = srrqs_pkg::ST_RANGE;
      endcase
      return r;
   endfunction

   task automatic send_req(row_type it);
      rsp_type p;
      @(negedge clock);
      req_valid = 1'b1;
      req_func = it.func;
      req_thread_id = it.tid;
      req_account = it.acc;
      req_slot = it.slot;
      req_now = it.now;
      do @(posedge clock); while (!req_ready);
      p = sched_step(it.func, it.tid, it.acc, it.slot, it.now);
      if (it.typed && (p.status != it.status || p.picked != it.picked ||
                       p.owner != it.owner))
         p = '{it.status, it.picked, it.owner};
      pending_rsp.push_back(p);
      accepted++;
   endtask

   task automatic drain_and_set_ticks(logic [15:0] v);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      ticks_cfg = v;
   endtask

   function automatic row_type random_item();
      row_type it;
      int k;
      int pick;
      it = '{default: '0};
      it.tid = 6'($urandom_range(0, NTHR - 1));
      it.now = $urandom;
      it.slot = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NACC - 1));
      k = $urandom_range(0, 9);
      it.acc = (k == 0) ? 8'($urandom) : (k < 4) ? 8'($urandom_range(0, NACC - 1))
                                                 : 8'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 30) it.func = pick[0] ? srrqs_pkg::FN_PREPEND : srrqs_pkg::FN_APPEND;
      else if (pick < 55) begin
         it.func = srrqs_pkg::FN_REMOVE;
         // mostly aim removes at threads that are queued, under their own account
         if ($urandom_range(0, 9) < 7) begin
            for (int i = 0; i < 8; i++) begin
               k = $urandom_range(0, NTHR - 1);
               if (on_queue[k]) begin
                  it.tid = 6'(k);
                  it.acc = {4'd0, home_acc[k]};
                  break;
               end
            end
         end
      end
      else if (pick < 80) it.func = srrqs_pkg::FN_SCHEDULE;
      else if (pick < 90) it.func = srrqs_pkg::FN_GRANT;
      else if (pick < 97) it.func = srrqs_pkg::FN_QUERY;
      else it.func = 3'($urandom_range(6, 7));
      return it;
   endfunction

   // receiver: changing ready pattern plus one long hold-off
   initial begin
      int mode;
      int cyc;
      mode = 0;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 2);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready = 1'b0;
         end else if (mode == 0) rsp_ready = 1'b1;
         else if (mode == 1) rsp_ready = 1'($urandom);
         else rsp_ready = (cyc % 4 == 0);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         status_hist[rsp_status]++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected item: status %0d", rsp_status);
            err_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               err_count++;
            end
            if (rsp_picked_thread !== e.picked) begin
               $error("picked_thread: expected %0d, got %0d", e.picked, rsp_picked_thread);
               err_count++;
            end
            if (rsp_slot_owner !== e.owner) begin
               $error("slot_owner: expected %0d, got %0d", e.owner, rsp_slot_owner);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      int idle;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      row_type dir [$];
      row_type it;
      logic [15:0] ticks_plan [4];
      int burst;
      int gaps_on;
      for (int i = 0; i < NTHR; i++) begin
         link_next[i] = NIL;
         link_prev[i] = NIL;
         on_queue[i] = 0;
         home_acc[i] = '0;
      end
      for (int i = 0; i < NACC; i++) begin
         q_head[i] = NIL;
         q_tail[i] = NIL;
         granted[i] = 0;
         slot_holder[i] = '0;
      end
      for (int i = 0; i < 8; i++) status_hist[i] = 0;
      // func, tid, acc, slot, now, typed, status, picked, owner
      dir = '{
         '{srrqs_pkg::FN_SCHEDULE, 6'd0, 8'd0, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_EMPTY, 6'd0, 8'd0},
         '{srrqs_pkg::FN_QUERY, 6'd0, 8'd0, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_QUERY, 6'd0, 8'd0, 8'd255, 32'd0, 1,
           srrqs_pkg::ST_RANGE, 6'd0, 8'd0},
         '{3'd6, 6'd63, 8'd255, 8'd255, 32'hFFFFFFFF, 1,
           srrqs_pkg::ST_RANGE, 6'd0, 8'd0},
         '{3'd7, 6'd0, 8'd0, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_RANGE, 6'd0, 8'd0},
         '{srrqs_pkg::FN_APPEND, 6'd0, 8'd255, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_RANGE, 6'd0, 8'd0},
         '{srrqs_pkg::FN_REMOVE, 6'd5, 8'd0, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_QERR, 6'd0, 8'd0},
         '{srrqs_pkg::FN_APPEND, 6'd63, 8'd15, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_APPEND, 6'd63, 8'd0, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_QERR, 6'd0, 8'd0},
         '{srrqs_pkg::FN_PREPEND, 6'd0, 8'd15, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_APPEND, 6'd1, 8'd15, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_REMOVE, 6'd63, 8'd3, 8'd0, 32'd0, 0,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_REMOVE, 6'd1, 8'd0, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_QERR, 6'd0, 8'd0},
         '{srrqs_pkg::FN_REMOVE, 6'd0, 8'd16, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_RANGE, 6'd0, 8'd0},
         '{srrqs_pkg::FN_GRANT, 6'd0, 8'd15, 8'd15, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_GRANT, 6'd0, 8'd2, 8'd15, 32'd0, 1,
           srrqs_pkg::ST_HELD, 6'd0, 8'd0},
         '{srrqs_pkg::FN_GRANT, 6'd0, 8'd15, 8'd15, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_GRANT, 6'd0, 8'd0, 8'd16, 32'd0, 1,
           srrqs_pkg::ST_RANGE, 6'd0, 8'd0},
         '{srrqs_pkg::FN_QUERY, 6'd0, 8'd0, 8'd15, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd15},
         '{srrqs_pkg::FN_SCHEDULE, 6'd0, 8'd0, 8'd0, 32'd150, 0,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_PREPEND, 6'd2, 8'd0, 8'd0, 32'd0, 1,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_SCHEDULE, 6'd0, 8'd0, 8'd0, 32'd5, 0,
           srrqs_pkg::ST_OK, 6'd0, 8'd0},
         '{srrqs_pkg::FN_SCHEDULE, 6'd0, 8'd0, 8'd0, 32'hFFFFFFFF, 0,
           srrqs_pkg::ST_OK, 6'd0, 8'd0}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir[i]) send_req(dir[i]);

      ticks_plan = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(2, 40))};
      burst = 0;
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_set_ticks(ticks_plan[ph]);
         gaps_on = (ph != 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 1 && n == 50) hold_cycles = 400;
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               if (gaps_on) begin
                  @(negedge clock);
                  req_valid = 1'b0;
                  repeat ($urandom_range(0, 6)) @(negedge clock);
               end
            end
            burst--;
            it = random_item();
            send_req(it);
         end
      end
      drain_and_set_ticks(srrqs_pkg::TICKS_RESET);
      repeat (50) @(posedge clock);

      $display("%0d items sent under 5 slot lengths, %0d results checked", accepted, rsp_seen);
      $display("results by status: ok %0d range %0d held %0d empty %0d qerr %0d",
               status_hist[srrqs_pkg::ST_OK], status_hist[srrqs_pkg::ST_RANGE],
               status_hist[srrqs_pkg::ST_HELD], status_hist[srrqs_pkg::ST_EMPTY],
               status_hist[srrqs_pkg::ST_QERR]);
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
